// ===== design/lqm_pkg.sv =====
// Shared constants, codes and interface structs of the linked queue manager.
package lqm_pkg;

    localparam int NODES    = 64;
    localparam int QUEUES   = 8;
    localparam int NODE_W   = 6;
    localparam int QUEUE_W  = 3;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = $clog2(NODES + 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_SIZE   = 2'd2
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_QUEUED     = 2'd1,
        ST_EMPTY      = 2'd2,
        ST_NOT_MEMBER = 2'd3
    } t_status;

    // Per-node state seen by the update logic for the node of the request.
    typedef struct packed {
        logic [NODE_W-1:0]  next_link;
        logic [NODE_W-1:0]  prev_link;
        logic [QUEUE_W-1:0] owner;
        logic               linked;
    } t_node_rd;

    typedef struct packed {
        logic               next_we;
        logic [NODE_W-1:0]  next_addr;
        logic [NODE_W-1:0]  next_data;
        logic               prev_we;
        logic [NODE_W-1:0]  prev_addr;
        logic [NODE_W-1:0]  prev_data;
        logic               link_set;
        logic               link_clr;
        logic [QUEUE_W-1:0] owner;
    } t_node_wr;

    typedef struct packed {
        logic [NODE_W-1:0]  head;
        logic [NODE_W-1:0]  tail;
        logic               nonempty;
        logic [COUNT_W-1:0] count;
    } t_queue_ent;

    typedef struct packed {
        logic       we;
        t_queue_ent ent;
    } t_queue_wr;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [NODE_W-1:0]   removed_node;
        logic [COUNT_W-1:0]  count;
        logic                head_valid;
        logic [NODE_W-1:0]   head_node;
    } t_result;

endpackage

// ===== design/linked_queue_manager_unit.sv =====
// Top level of the linked queue manager: request register, update logic and result register.
//
// Keeps a pool of 64 nodes linked into 8 circular doubly linked queues and
// answers every append, remove or size request with exactly one result. One
// request is taken per clock cycle, except while the request register holds a
// request whose result waits for a result register that is not being drained;
// a request waits in the request register while the node link and owner RAMs
// are read; the result register holds it until taken. The successor, predecessor
// and owner of the request's node come from RAMs with a registered read, and
// the last write of each RAM is forwarded to the following request. Queue
// heads, tails and counts and the per-node linked flags are flip-flops, so a
// request sees all earlier requests' updates. The request register takes a new
// request while a finished result waits to be taken.
module linked_queue_manager_unit import lqm_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [CMD_W-1:0]    i_cmd,
    input  logic [QUEUE_W-1:0]  i_queue_id,
    input  logic [NODE_W-1:0]   i_node_id,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [STATUS_W-1:0] o_status,
    output logic [NODE_W-1:0]   o_removed_node,
    output logic [COUNT_W-1:0]  o_count,
    output logic                o_head_valid,
    output logic [NODE_W-1:0]   o_head_node
);

    logic               r_s_valid;
    logic               n_s_valid;
    logic [CMD_W-1:0]   r_cmd;
    logic [QUEUE_W-1:0] r_queue_id;
    logic [NODE_W-1:0]  r_node_id;
    logic               r_o_valid;
    logic               n_o_valid;
    t_result            r_result;

    logic       w_commit;
    logic       w_accept;
    t_node_rd   w_node_rd;
    t_node_wr   w_node_wr;
    t_queue_ent w_queue_rd;
    t_queue_wr  w_queue_wr;
    t_result    w_result;

    assign w_commit   = r_s_valid && (!r_o_valid || i_out_ready);
    assign o_in_ready = !r_s_valid || w_commit;
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_s_valid = r_s_valid;
        if (w_accept) begin
            n_s_valid = 1'b1;
        end else if (w_commit) begin
            n_s_valid = 1'b0;
        end
        n_o_valid = r_o_valid;
        if (w_commit) begin
            n_o_valid = 1'b1;
        end else if (i_out_ready) begin
            n_o_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_s_valid <= n_s_valid;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd      <= i_cmd;
            r_queue_id <= i_queue_id;
            r_node_id  <= i_node_id;
        end
        if (w_commit) begin
            r_result <= w_result;
        end
    end

    lqm_node_store u_node_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_accept),
        .i_rd_node (i_node_id),
        .i_node    (r_node_id),
        .i_wr      (w_node_wr),
        .o_rd      (w_node_rd)
    );

    lqm_queue_table u_queue_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_queue (r_queue_id),
        .i_wr    (w_queue_wr),
        .o_rd    (w_queue_rd)
    );

    lqm_exec u_exec (
        .i_go       (w_commit),
        .i_cmd      (r_cmd),
        .i_queue    (r_queue_id),
        .i_node     (r_node_id),
        .i_node_rd  (w_node_rd),
        .i_queue_rd (w_queue_rd),
        .o_node_wr  (w_node_wr),
        .o_queue_wr (w_queue_wr),
        .o_result   (w_result)
    );

    assign o_out_valid    = r_o_valid;
    assign o_status       = r_result.status;
    assign o_removed_node = r_result.removed_node;
    assign o_count        = r_result.count;
    assign o_head_valid   = r_result.head_valid;
    assign o_head_node    = r_result.head_node;

`ifndef SYNTHESIS
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_s_valid && r_o_valid && !i_out_ready))
        else $error("request stage stalled without a blocked result");

    a_commit_fills_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |=> o_out_valid)
        else $error("processed request produced no result");

    a_head_implies_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_head_valid) |-> (o_count != '0))
        else $error("non-empty queue reported with zero count");
`endif

endmodule

// ===== design/lqm_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module lqm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/lqm_node_store.sv =====
// Per-node storage: link and owner RAMs with write forwarding, and the linked flags.
module lqm_node_store import lqm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [NODE_W-1:0] i_rd_node,
    input  logic [NODE_W-1:0] i_node,
    input  t_node_wr          i_wr,
    output t_node_rd          o_rd
);

    logic [NODE_W-1:0]  w_next_q;
    logic [NODE_W-1:0]  w_prev_q;
    logic [QUEUE_W-1:0] w_owner_q;

    logic               r_fwd_next_vld;
    logic [NODE_W-1:0]  r_fwd_next_addr;
    logic [NODE_W-1:0]  r_fwd_next_data;
    logic               r_fwd_prev_vld;
    logic [NODE_W-1:0]  r_fwd_prev_addr;
    logic [NODE_W-1:0]  r_fwd_prev_data;
    logic               r_fwd_own_vld;
    logic [NODE_W-1:0]  r_fwd_own_addr;
    logic [QUEUE_W-1:0] r_fwd_own_data;
    logic [NODES-1:0]   r_linked;

    lqm_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (i_wr.next_we),
        .i_waddr (i_wr.next_addr),
        .i_wdata (i_wr.next_data),
        .i_re    (i_rd_en),
        .i_raddr (i_rd_node),
        .o_rdata (w_next_q)
    );

    lqm_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (i_wr.prev_we),
        .i_waddr (i_wr.prev_addr),
        .i_wdata (i_wr.prev_data),
        .i_re    (i_rd_en),
        .i_raddr (i_rd_node),
        .o_rdata (w_prev_q)
    );

    lqm_ram #(.WIDTH(QUEUE_W), .DEPTH(NODES)) u_owner_ram (
        .i_clk   (i_clk),
        .i_we    (i_wr.link_set),
        .i_waddr (i_node),
        .i_wdata (i_wr.owner),
        .i_re    (i_rd_en),
        .i_raddr (i_rd_node),
        .o_rdata (w_owner_q)
    );

    // The read for a request may be taken at the same edge as the previous request's
    // write, so the RAM returns old data; the last write of each RAM is kept here.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_next_vld <= 1'b0;
            r_fwd_prev_vld <= 1'b0;
            r_fwd_own_vld  <= 1'b0;
            r_linked       <= '0;
        end else begin
            if (i_wr.next_we) begin
                r_fwd_next_vld <= 1'b1;
            end
            if (i_wr.prev_we) begin
                r_fwd_prev_vld <= 1'b1;
            end
            if (i_wr.link_set) begin
                r_fwd_own_vld    <= 1'b1;
                r_linked[i_node] <= 1'b1;
            end else if (i_wr.link_clr) begin
                r_linked[i_node] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.next_we) begin
            r_fwd_next_addr <= i_wr.next_addr;
            r_fwd_next_data <= i_wr.next_data;
        end
        if (i_wr.prev_we) begin
            r_fwd_prev_addr <= i_wr.prev_addr;
            r_fwd_prev_data <= i_wr.prev_data;
        end
        if (i_wr.link_set) begin
            r_fwd_own_addr <= i_node;
            r_fwd_own_data <= i_wr.owner;
        end
    end

    always_comb begin
        o_rd.next_link = (r_fwd_next_vld && r_fwd_next_addr == i_node) ?
                         r_fwd_next_data : w_next_q;
        o_rd.prev_link = (r_fwd_prev_vld && r_fwd_prev_addr == i_node) ?
                         r_fwd_prev_data : w_prev_q;
        o_rd.owner     = (r_fwd_own_vld && r_fwd_own_addr == i_node) ?
                         r_fwd_own_data : w_owner_q;
        o_rd.linked    = r_linked[i_node];
    end

endmodule

// ===== design/lqm_queue_table.sv =====
// Per-queue head, tail, non-empty flag and node count held in flip-flops.
module lqm_queue_table import lqm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [QUEUE_W-1:0] i_queue,
    input  t_queue_wr          i_wr,
    output t_queue_ent         o_rd
);

    logic [NODE_W-1:0]  r_head [QUEUES];
    logic [NODE_W-1:0]  r_tail [QUEUES];
    logic [QUEUES-1:0]  r_nonempty;
    logic [COUNT_W-1:0] r_count [QUEUES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nonempty <= '0;
            for (int i = 0; i < QUEUES; i++) begin
                r_count[i] <= '0;
            end
        end else if (i_wr.we) begin
            r_nonempty[i_queue] <= i_wr.ent.nonempty;
            r_count[i_queue]    <= i_wr.ent.count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_head[i_queue] <= i_wr.ent.head;
            r_tail[i_queue] <= i_wr.ent.tail;
        end
    end

    always_comb begin
        o_rd.head     = r_head[i_queue];
        o_rd.tail     = r_tail[i_queue];
        o_rd.nonempty = r_nonempty[i_queue];
        o_rd.count    = r_count[i_queue];
    end

`ifndef SYNTHESIS
    // The queue index comes from the request register, which is unknown until the first request.
    a_count_matches_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$isunknown(i_queue) |-> (o_rd.nonempty == (o_rd.count != '0)))
        else $error("queue count and non-empty flag disagree");
`endif

endmodule

// ===== design/lqm_exec.sv =====
// Command decode and list update: computes state writes and the result of one request.
module lqm_exec import lqm_pkg::*; (
    input  logic               i_go,
    input  logic [CMD_W-1:0]   i_cmd,
    input  logic [QUEUE_W-1:0] i_queue,
    input  logic [NODE_W-1:0]  i_node,
    input  t_node_rd           i_node_rd,
    input  t_queue_ent         i_queue_rd,
    output t_node_wr           o_node_wr,
    output t_queue_wr          o_queue_wr,
    output t_result            o_result
);

    logic       w_qok;
    logic       w_nok;
    t_node_wr   w_nwr;
    t_queue_ent w_ent;
    logic       w_qwe;
    t_status    w_status;
    logic       w_removed;
    logic       w_is_head;
    logic       w_is_tail;
    logic [NODE_W-1:0] w_nx;
    logic [NODE_W-1:0] w_pv;

    assign w_qok     = 32'(i_queue) < QUEUES;
    assign w_nok     = 32'(i_node) < NODES;
    assign w_is_head = i_queue_rd.head == i_node;
    assign w_is_tail = i_queue_rd.tail == i_node;
    // The tail's successor and the head's predecessor are not stored; they
    // come from the queue's head and tail.
    assign w_nx      = w_is_tail ? i_queue_rd.head : i_node_rd.next_link;
    assign w_pv      = w_is_head ? i_queue_rd.tail : i_node_rd.prev_link;

    always_comb begin
        w_nwr          = '0;
        w_nwr.owner    = i_queue;
        w_ent          = i_queue_rd;
        w_qwe          = 1'b0;
        w_status       = ST_OK;
        w_removed      = 1'b0;
        unique case (i_cmd)
            CMD_APPEND: begin
                if (!w_qok || !w_nok || i_node_rd.linked) begin
                    w_status = ST_QUEUED;
                end else if (!i_queue_rd.nonempty) begin
                    w_ent.head     = i_node;
                    w_ent.tail     = i_node;
                    w_ent.nonempty = 1'b1;
                    w_ent.count    = COUNT_W'(1);
                    w_qwe          = 1'b1;
                    w_nwr.link_set = 1'b1;
                end else begin
                    w_nwr.next_we   = 1'b1;
                    w_nwr.next_addr = i_queue_rd.tail;
                    w_nwr.next_data = i_node;
                    w_nwr.prev_we   = 1'b1;
                    w_nwr.prev_addr = i_node;
                    w_nwr.prev_data = i_queue_rd.tail;
                    w_ent.tail      = i_node;
                    w_ent.count     = COUNT_W'(i_queue_rd.count + 1'b1);
                    w_qwe           = 1'b1;
                    w_nwr.link_set  = 1'b1;
                end
            end
            CMD_REMOVE: begin
                if (!w_qok || !i_queue_rd.nonempty) begin
                    w_status = ST_EMPTY;
                end else if (!w_nok || !i_node_rd.linked || i_node_rd.owner != i_queue) begin
                    w_status = ST_NOT_MEMBER;
                end else begin
                    w_removed      = 1'b1;
                    w_nwr.link_clr = 1'b1;
                    w_qwe          = 1'b1;
                    if (i_queue_rd.count <= COUNT_W'(1)) begin
                        w_ent.nonempty = 1'b0;
                        w_ent.count    = '0;
                    end else begin
                        w_ent.count = COUNT_W'(i_queue_rd.count - 1'b1);
                        if (w_is_head) begin
                            w_ent.head = w_nx;
                        end else if (w_is_tail) begin
                            w_ent.tail = w_pv;
                        end else begin
                            w_nwr.prev_we   = 1'b1;
                            w_nwr.prev_addr = w_nx;
                            w_nwr.prev_data = w_pv;
                            w_nwr.next_we   = 1'b1;
                            w_nwr.next_addr = w_pv;
                            w_nwr.next_data = w_nx;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_node_wr          = w_nwr;
        o_node_wr.next_we  = w_nwr.next_we & i_go;
        o_node_wr.prev_we  = w_nwr.prev_we & i_go;
        o_node_wr.link_set = w_nwr.link_set & i_go;
        o_node_wr.link_clr = w_nwr.link_clr & i_go;
        o_queue_wr.we      = w_qwe & i_go;
        o_queue_wr.ent     = w_ent;

        o_result.status       = w_status;
        o_result.removed_node = w_removed ? i_node : '0;
        if (w_qok && w_ent.nonempty) begin
            o_result.count      = w_ent.count;
            o_result.head_valid = 1'b1;
            o_result.head_node  = w_ent.head;
        end else begin
            o_result.count      = '0;
            o_result.head_valid = 1'b0;
            o_result.head_node  = '0;
        end
    end

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench of the linked queue manager with a tracked copy of every queue.
module tb;
    import lqm_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int RANDOM_REQUESTS = 1300;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int SETTLE_CYCLES   = 10;

    class lqm_scoreboard;
        bit [NODE_W-1:0]  next_of [NODES];
        bit [NODE_W-1:0]  prev_of [NODES];
        bit               linked [NODES];
        bit [QUEUE_W-1:0] owner [NODES];
        bit [NODE_W-1:0]  head [QUEUES];
        bit               nonempty [QUEUES];
        int unsigned      count [QUEUES];
        t_result          pending_answers [$];
        int               failures;
        int               shown;

        // Applies one accepted request to the tracked queues and queues the answer it must produce.
        function void note_request(logic [CMD_W-1:0] cmd, logic [QUEUE_W-1:0] q,
                                   logic [NODE_W-1:0] n);
            t_result         ans;
            bit              q_ok;
            bit              n_ok;
            bit [NODE_W-1:0] first;
            bit [NODE_W-1:0] last;
            bit [NODE_W-1:0] nx;
            bit [NODE_W-1:0] pv;
            ans  = '0;
            q_ok = int'(q) < QUEUES;
            n_ok = int'(n) < NODES;
            if (cmd == CMD_APPEND) begin
                if (!q_ok || !n_ok || linked[n]) begin
                    ans.status = ST_QUEUED;
                end else if (!nonempty[q]) begin
                    head[q]     = n;
                    next_of[n]  = n;
                    prev_of[n]  = n;
                    linked[n]   = 1'b1;
                    owner[n]    = q;
                    nonempty[q] = 1'b1;
                    count[q]    = 1;
                end else begin
                    first          = head[q];
                    last           = prev_of[first];
                    next_of[last]  = n;
                    prev_of[n]     = last;
                    next_of[n]     = first;
                    prev_of[first] = n;
                    linked[n]      = 1'b1;
                    owner[n]       = q;
                    count[q]++;
                end
            end else if (cmd == CMD_REMOVE) begin
                // An empty queue is reported before membership is looked at.
                if (!q_ok || !nonempty[q]) begin
                    ans.status = ST_EMPTY;
                end else if (!n_ok || !linked[n] || owner[n] != q) begin
                    ans.status = ST_NOT_MEMBER;
                end else begin
                    nx          = next_of[n];
                    pv          = prev_of[n];
                    prev_of[nx] = pv;
                    next_of[pv] = nx;
                    if (count[q] <= 1) begin
                        nonempty[q] = 1'b0;
                        count[q]    = 0;
                    end else begin
                        count[q]--;
                        if (head[q] == n) head[q] = nx;
                    end
                    linked[n]        = 1'b0;
                    ans.removed_node = n;
                end
            end
            if (q_ok && nonempty[q]) begin
                ans.count      = COUNT_W'(count[q]);
                ans.head_valid = 1'b1;
                ans.head_node  = head[q];
            end
            pending_answers.push_back(ans);
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending_answers.size() == 0) begin
                failures++;
                if (shown < 10) begin
                    shown++;
                    $display("result with nothing outstanding: status %0d removed %0d count %0d head %0d/%0d",
                             got.status, got.removed_node, got.count, got.head_valid, got.head_node);
                end
                return;
            end
            want = pending_answers.pop_front();
            if (got.status !== want.status || got.removed_node !== want.removed_node ||
                got.count !== want.count || got.head_valid !== want.head_valid ||
                got.head_node !== want.head_node) begin
                failures++;
                if (shown < 10) begin
                    shown++;
                    $display("mismatch: expected status %0d removed %0d count %0d head %0d/%0d",
                             want.status, want.removed_node, want.count, want.head_valid,
                             want.head_node);
                    $display("          got      status %0d removed %0d count %0d head %0d/%0d",
                             got.status, got.removed_node, got.count, got.head_valid,
                             got.head_node);
                end
            end
        endfunction

        function int free_nodes();
            int total;
            total = 0;
            for (int i = 0; i < NODES; i++) if (!linked[i]) total++;
            return total;
        endfunction

        // Caller makes sure at least one node is free.
        function bit [NODE_W-1:0] pick_free();
            bit [NODE_W-1:0] pool [$];
            for (int i = 0; i < NODES; i++) if (!linked[i]) pool.push_back(NODE_W'(i));
            return pool[$urandom_range(0, pool.size() - 1)];
        endfunction

        // Mode 0 takes the head, 1 the tail, anything else a random member.
        function bit [NODE_W-1:0] pick_member(bit [QUEUE_W-1:0] q, int mode);
            bit [NODE_W-1:0] node;
            int              steps;
            node = head[q];
            if (mode == 0) return node;
            if (mode == 1) return prev_of[node];
            steps = $urandom_range(0, count[q] - 1);
            repeat (steps) node = next_of[node];
            return node;
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [CMD_W-1:0]   i_cmd = CMD_SIZE;
    logic [QUEUE_W-1:0] i_queue_id = '0;
    logic [NODE_W-1:0]  i_node_id = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [STATUS_W-1:0] o_status;
    logic [NODE_W-1:0]  o_removed_node;
    logic [COUNT_W-1:0] o_count;
    logic               o_head_valid;
    logic [NODE_W-1:0]  o_head_node;

    lqm_scoreboard sb = new();
    bit  send_idle = 1'b1;
    bit  recv_idle = 1'b1;
    int  requests_sent = 0;
    int  cycle_count = 0;

    linked_queue_manager_unit DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_cmd          (i_cmd),
        .i_queue_id     (i_queue_id),
        .i_node_id      (i_node_id),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_removed_node (o_removed_node),
        .o_count        (o_count),
        .o_head_valid   (o_head_valid),
        .o_head_node    (o_head_node)
    );

    always #4 i_clk = ~i_clk;

    task automatic send_request(logic [CMD_W-1:0] cmd, logic [QUEUE_W-1:0] q,
                                logic [NODE_W-1:0] n);
        int gap;
        gap = send_idle ? $urandom_range(0, 8) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd      <= cmd;
        i_queue_id <= q;
        i_node_id  <= n;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_request(cmd, q, n);
        requests_sent++;
    endtask

    // Holds the next request back until every outstanding answer has come out.
    task automatic pause_until_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending_answers.size() != 0);
    endtask

    task automatic fill_and_drain(bit [QUEUE_W-1:0] q);
        while (sb.free_nodes() > 0) send_request(CMD_APPEND, q, sb.pick_free());
        send_request(CMD_SIZE, q, NODE_W'($urandom));
        send_request(CMD_APPEND, QUEUE_W'($urandom), NODE_W'($urandom));
        while (sb.nonempty[q]) send_request(CMD_REMOVE, q, sb.pick_member(q, $urandom_range(0, 2)));
    endtask

    task automatic random_request();
        int                 roll;
        bit [QUEUE_W-1:0]   q;
        roll = $urandom_range(0, 99);
        q    = QUEUE_W'($urandom_range(0, QUEUES - 1));
        if (roll < 10) begin
            send_request(CMD_W'($urandom_range(0, 3)), QUEUE_W'($urandom), NODE_W'($urandom));
        end else if (roll < 20) begin
            send_request(CMD_SIZE, q, NODE_W'($urandom));
        end else if (roll < 60) begin
            if (sb.free_nodes() > 0) send_request(CMD_APPEND, q, sb.pick_free());
            else send_request(CMD_APPEND, q, NODE_W'($urandom));
        end else begin
            // Look for a queue with members so that most removes succeed.
            for (int tries = 0; tries < 8 && !sb.nonempty[q]; tries++)
                q = QUEUE_W'($urandom_range(0, QUEUES - 1));
            if (sb.nonempty[q]) send_request(CMD_REMOVE, q, sb.pick_member(q, $urandom_range(0, 3)));
            else send_request(CMD_REMOVE, q, NODE_W'($urandom));
        end
    endtask

    task automatic run_receiver();
        int      stall;
        t_result got;
        forever begin
            stall = recv_idle ? $urandom_range(0, 8) : 0;
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && i_out_ready));
            got.status       = o_status;
            got.removed_node = o_removed_node;
            got.count        = o_count;
            got.head_valid   = o_head_valid;
            got.head_node    = o_head_node;
            sb.check_result(got);
        end
    endtask

    initial begin
        wait (i_rst_n);
        run_receiver();
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests: empty queues, unused command, errors and head, tail and sole-node removes.
        send_request(CMD_SIZE,   3'd0, 6'd0);
        send_request(CMD_REMOVE, 3'd3, 6'd5);
        send_request(CMD_UNUSED, 3'd0, 6'd0);
        send_request(CMD_APPEND, 3'd0, 6'd0);
        send_request(CMD_APPEND, 3'd0, 6'd63);
        send_request(CMD_APPEND, 3'd0, 6'd21);
        send_request(CMD_APPEND, 3'd7, 6'd63);
        send_request(CMD_APPEND, 3'd7, 6'd42);
        send_request(CMD_REMOVE, 3'd7, 6'd0);
        send_request(CMD_REMOVE, 3'd0, 6'd42);
        send_request(CMD_REMOVE, 3'd0, 6'd5);
        send_request(CMD_REMOVE, 3'd0, 6'd0);
        send_request(CMD_REMOVE, 3'd0, 6'd21);
        send_request(CMD_SIZE,   3'd0, 6'd63);
        send_request(CMD_REMOVE, 3'd0, 6'd63);
        send_request(CMD_REMOVE, 3'd0, 6'd63);
        send_request(CMD_UNUSED, 3'd7, 6'd63);
        send_request(CMD_APPEND, 3'd7, 6'd0);
        send_request(CMD_REMOVE, 3'd7, 6'd42);
        send_request(CMD_REMOVE, 3'd7, 6'd0);
        send_request(CMD_SIZE,   3'd7, 6'd0);
        pause_until_drained();

        // Every node in one queue drives the count to 64, the pool size.
        fill_and_drain(QUEUE_W'($urandom_range(0, QUEUES - 1)));

        while (requests_sent < RANDOM_REQUESTS + 21) begin
            send_idle = $urandom_range(0, 3) != 0;
            recv_idle = $urandom_range(0, 3) != 0;
            if ($urandom_range(0, 9) == 0) fill_and_drain(QUEUE_W'($urandom_range(0, QUEUES - 1)));
            else repeat (60) random_request();
            if ($urandom_range(0, 3) == 0) pause_until_drained();
        end

        i_in_valid <= 1'b0;
        while (sb.pending_answers.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== files.f =====
design/lqm_pkg.sv
design/lqm_ram.sv
design/lqm_node_store.sv
design/lqm_queue_table.sv
design/lqm_exec.sv
design/linked_queue_manager_unit.sv
sim/tb.sv
